// File: src/radio_tuning_controller_core_defines.svh
// Assertion macros used by the tuning controller core.
`ifndef RADIO_TUNING_CONTROLLER_CORE_DEFINES_SVH
`define RADIO_TUNING_CONTROLLER_CORE_DEFINES_SVH

// Check a property on every rising edge of clk, idle while arst_n is low.
`define RTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define RTC_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rtc_pkg.sv
// Types, codes and constant tables of the radio tuning controller.
package rtc_pkg;

	// Field widths
	localparam int DIAL_W     = 26;
	localparam int PITCH_W    = 12;
	localparam int STEP_HZ_W  = 20;
	localparam int STEP_W     = 3;
	localparam int FILTER_W   = 4;
	localparam int DELTA_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;

	// Sizing
	localparam int BAND_COUNT_DEF = 10;
	localparam int BAND_MAX       = 16;
	localparam int STEP_COUNT     = 7;

	// Reset values
	localparam logic [DIAL_W-1:0]  MIN_FREQ_RST = 26'd1000000;
	localparam logic [DIAL_W-1:0]  MAX_FREQ_RST = 26'd54000000;
	localparam logic [PITCH_W-1:0] PITCH_RST    = 12'd700;
	localparam logic [DIAL_W-1:0]  DIAL_RST     = 26'd1825000;
	localparam int                 BAND_RST     = 1;
	localparam int                 STEP_RST     = 2;

	// Command codes carried in req_type
	typedef enum logic [2:0] {
		REQ_TUNE = 3'd0,
		REQ_MODE = 3'd1,
		REQ_BAND = 3'd2,
		REQ_STEP = 3'd3,
		REQ_SAVE = 3'd4,
		REQ_TX   = 3'd5,
		REQ_OFF  = 3'd6,
		REQ_WAKE = 3'd7
	} req_t;

	// Operating modes
	typedef enum logic [2:0] {
		MODE_LSB  = 3'd0,
		MODE_USB  = 3'd1,
		MODE_CW   = 3'd2,
		MODE_FT8  = 3'd3,
		MODE_WSPR = 3'd4
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_FREQ = 2'd0,
		CFG_MAX_FREQ = 2'd1,
		CFG_CW_PITCH = 2'd2
	} cfg_idx_t;

	// Power-up frequency of each band
	localparam logic [DIAL_W-1:0] BAND_DEFAULTS [BAND_MAX] = '{
		26'd1900000,  26'd3575000,  26'd7067000,  26'd10136000,
		26'd14074000, 26'd18100000, 26'd21074000, 26'd24915000,
		26'd28074000, 26'd50313000, 26'd1000000,  26'd1000000,
		26'd1000000,  26'd1000000,  26'd1000000,  26'd1000000
	};

	// Tuning step in hertz for a step selector
	function automatic logic [STEP_HZ_W-1:0] step_hz_of(input logic [STEP_W-1:0] sel);
		logic [STEP_HZ_W-1:0] hz;
		case (sel)
			3'd0:    hz = 20'd1;
			3'd1:    hz = 20'd10;
			3'd2:    hz = 20'd100;
			3'd3:    hz = 20'd1000;
			3'd4:    hz = 20'd10000;
			3'd5:    hz = 20'd100000;
			3'd6:    hz = 20'd1000000;
			default: hz = 20'd1;
		endcase
		return hz;
	endfunction

endpackage

// File: src/radio_tuning_controller_core.sv
// Radio tuning controller: command decode, band memory and result register.
`include "radio_tuning_controller_core_defines.svh"

// Front-panel controller for a receiver. Each command item on the s_axis side
// updates the tuning state (dial, mode, band, step, transmit, soft off) and
// yields exactly one result item on the m_axis side with the dial and LO
// frequencies, mute lines, filter code and a save request. An accepted item is
// held in an input register, then the whole state update (one 8x21 multiply,
// add and clamp for tuning, or a band memory swap) is done combinationally
// and the result is loaded into the output register when that register is
// free or being read. The block takes one item per clock when the output side
// keeps up; each result passes the input register and then the output register
// before it can be taken. The band memory sits in flip-flops that reset loads
// with the default band frequencies, so no clearing pass follows reset.
// Configuration writes are always taken.
module radio_tuning_controller_core
	import rtc_pkg::*;
#(
	parameter int BAND_COUNT = BAND_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command items
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // req_type[2:0], tune_delta[10:3], zero pad
	// result items
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// dial_hz[25:0], lo_hz[51:26], quad_reverse[52], rx_muted[53], ssb_muted[54],
	// cw_muted[55], mode_code[58:56], filter_code[62:59], step_hz[82:63],
	// lo_enabled[83], powered_off[84], save_request[85], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIAL_W-1:0]     cfg_data
);

	localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int SUM_W  = DIAL_W + 4;
	localparam int PROD_W = DELTA_W + STEP_HZ_W + 1;

	// Configuration
	logic [DIAL_W-1:0]  min_freq_q;
	logic [DIAL_W-1:0]  max_freq_q;
	logic [PITCH_W-1:0] pitch_q;

	// Input stage
	logic               valid_s1;
	req_t               req_s1;
	logic [DELTA_W-1:0] delta_s1;

	// Tuning state
	logic [DIAL_W-1:0]  dial_q;
	mode_t              mode_q;
	logic [BAND_W-1:0]  band_q;
	logic [STEP_W-1:0]  step_q;
	logic               dirty_q;
	logic               tx_q;
	logic               off_q;
	logic [DIAL_W-1:0]  mem_freq_q [BAND_COUNT];
	mode_t              mem_mode_q [BAND_COUNT];

	// Output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic advance;

	// Next state and memory writes
	logic [DIAL_W-1:0]  dial_nx;
	mode_t              mode_nx;
	logic [BAND_W-1:0]  band_nx;
	logic [STEP_W-1:0]  step_nx;
	logic               dirty_nx;
	logic               tx_nx;
	logic               off_nx;
	logic               save_nx;
	logic               wr_cur_f;
	logic               wr_cur_m;
	logic [DIAL_W-1:0]  wr_cur_freq;
	mode_t              wr_cur_mode;
	logic               wr_new;

	// Datapath
	logic [STEP_HZ_W-1:0]    step_hz_cur;
	logic signed [PROD_W-1:0] tune_prod;
	logic signed [SUM_W-1:0]  tune_sum;
	logic signed [SUM_W-1:0]  tune_raise;
	logic [DIAL_W-1:0]        tune_freq;
	logic [DIAL_W-1:0]        dial_clamp;
	logic [BAND_W-1:0]        band_next;
	logic [DIAL_W-1:0]        rd_freq;
	mode_t                    rd_mode;
	logic [DIAL_W-1:0]        rd_clamp;
	logic [DIAL_W-1:0]        lo_nx;
	logic                     quad_nx;
	logic                     rx_m_nx;
	logic                     ssb_m_nx;
	logic                     cw_m_nx;

	function automatic logic [DIAL_W-1:0] clamp_freq(
		input logic [DIAL_W-1:0] hz,
		input logic [DIAL_W-1:0] lo,
		input logic [DIAL_W-1:0] hi
	);
		logic [DIAL_W-1:0] r;
		r = (hz < lo) ? lo : hz;
		r = (r > hi) ? hi : r;
		return r;
	endfunction

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q <= MIN_FREQ_RST;
			max_freq_q <= MAX_FREQ_RST;
			pitch_q    <= PITCH_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_FREQ: min_freq_q <= cfg_data;
				CFG_MAX_FREQ: max_freq_q <= cfg_data;
				CFG_CW_PITCH: pitch_q    <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the accepted item in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1   <= req_t'(s_axis_tdata[2:0]);
			delta_s1 <= s_axis_tdata[10:3];
		end
	end

	// Tune: dial plus delta times step, clamped to the limits (maximum wins)
	assign step_hz_cur = step_hz_of(step_q);
	assign tune_prod   = $signed(delta_s1) * $signed({1'b0, step_hz_cur});
	assign tune_sum    = $signed({4'b0, dial_q}) + SUM_W'(tune_prod);

	// Raise to the minimum first, then lower the raised value to the maximum
	always_comb begin
		tune_raise = tune_sum;
		if (tune_sum < $signed({4'b0, min_freq_q})) begin
			tune_raise = $signed({4'b0, min_freq_q});
		end
		tune_freq = tune_raise[DIAL_W-1:0];
		if (tune_raise > $signed({4'b0, max_freq_q})) begin
			tune_freq = max_freq_q;
		end
	end

	// Band swap: next band and its stored settings
	assign dial_clamp = clamp_freq(dial_q, min_freq_q, max_freq_q);
	assign band_next  = (band_q == BAND_W'(BAND_COUNT - 1)) ? '0 : band_q + 1'b1;
	assign rd_freq    = (band_next == band_q) ? dial_clamp : mem_freq_q[band_next];
	assign rd_mode    = (band_next == band_q) ? mode_q : mem_mode_q[band_next];
	assign rd_clamp   = clamp_freq(rd_freq, min_freq_q, max_freq_q);

	// Decode the command
	always_comb begin
		dial_nx     = dial_q;
		mode_nx     = mode_q;
		band_nx     = band_q;
		step_nx     = step_q;
		dirty_nx    = dirty_q;
		tx_nx       = tx_q;
		off_nx      = off_q;
		save_nx     = 1'b0;
		wr_cur_f    = 1'b0;
		wr_cur_m    = 1'b0;
		wr_cur_freq = dial_clamp;
		wr_cur_mode = mode_q;
		wr_new      = 1'b0;
		if (off_q) begin
			if (req_s1 == REQ_WAKE) begin
				off_nx = 1'b0;
			end
		end else begin
			case (req_s1)
				REQ_TUNE: begin
					dial_nx     = tune_freq;
					wr_cur_f    = 1'b1;
					wr_cur_freq = tune_freq;
					dirty_nx    = 1'b1;
				end
				REQ_MODE: begin
					mode_nx     = (mode_q == MODE_WSPR) ? MODE_LSB : mode_t'(mode_q + 3'd1);
					wr_cur_f    = 1'b1;
					wr_cur_m    = 1'b1;
					wr_cur_mode = mode_nx;
					dirty_nx    = 1'b1;
				end
				REQ_BAND: begin
					wr_cur_f = 1'b1;
					wr_cur_m = 1'b1;
					band_nx  = band_next;
					dial_nx  = rd_freq;
					mode_nx  = rd_mode;
					wr_new   = 1'b1;
					dirty_nx = 1'b0;
					save_nx  = 1'b1;
				end
				REQ_STEP: begin
					step_nx  = (step_q == STEP_W'(STEP_COUNT - 1)) ? '0 : step_q + 1'b1;
					wr_cur_f = 1'b1;
					wr_cur_m = 1'b1;
					dirty_nx = 1'b1;
				end
				REQ_SAVE: begin
					if (dirty_q) begin
						wr_cur_f = 1'b1;
						wr_cur_m = 1'b1;
						dirty_nx = 1'b0;
						save_nx  = 1'b1;
					end
				end
				REQ_TX: begin
					tx_nx = !tx_q;
				end
				REQ_OFF: begin
					if (dirty_q) begin
						wr_cur_f = 1'b1;
						wr_cur_m = 1'b1;
						dirty_nx = 1'b0;
						save_nx  = 1'b1;
					end
					tx_nx  = 1'b0;
					off_nx = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Result lines from the updated state
	always_comb begin
		if (mode_nx == MODE_CW) begin
			lo_nx = (dial_nx > {{(DIAL_W-PITCH_W){1'b0}}, pitch_q})
				? dial_nx - {{(DIAL_W-PITCH_W){1'b0}}, pitch_q} : min_freq_q;
		end else begin
			lo_nx = dial_nx;
		end
		quad_nx = (mode_nx == MODE_USB) || (mode_nx == MODE_FT8) || (mode_nx == MODE_WSPR);
		if (off_nx || tx_nx) begin
			rx_m_nx  = 1'b1;
			ssb_m_nx = 1'b1;
			cw_m_nx  = 1'b1;
		end else begin
			rx_m_nx  = 1'b0;
			ssb_m_nx = (mode_nx == MODE_CW);
			cw_m_nx  = (mode_nx != MODE_CW);
		end
	end

	// Advance the tuning state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dial_q  <= DIAL_RST;
			mode_q  <= MODE_LSB;
			band_q  <= BAND_W'(BAND_RST % BAND_COUNT);
			step_q  <= STEP_W'(STEP_RST % STEP_COUNT);
			dirty_q <= 1'b0;
			tx_q    <= 1'b0;
			off_q   <= 1'b0;
		end else if (advance && valid_s1) begin
			dial_q  <= dial_nx;
			mode_q  <= mode_nx;
			band_q  <= band_nx;
			step_q  <= step_nx;
			dirty_q <= dirty_nx;
			tx_q    <= tx_nx;
			off_q   <= off_nx;
		end
	end

	// Band memory: current band store, then the new band's store wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_COUNT; i++) begin
				mem_freq_q[i] <= BAND_DEFAULTS[i];
				mem_mode_q[i] <= MODE_LSB;
			end
		end else if (advance && valid_s1) begin
			for (int i = 0; i < BAND_COUNT; i++) begin
				if (wr_new && (band_next == BAND_W'(i))) begin
					mem_freq_q[i] <= rd_clamp;
					mem_mode_q[i] <= rd_mode;
				end else if (band_q == BAND_W'(i)) begin
					if (wr_cur_f) begin
						mem_freq_q[i] <= wr_cur_freq;
					end
					if (wr_cur_m) begin
						mem_mode_q[i] <= wr_cur_mode;
					end
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {2'b00, save_nx, off_nx, !off_nx, step_hz_of(step_nx),
				off_nx ? {FILTER_W{1'b0}} : FILTER_W'(band_nx), mode_nx,
				cw_m_nx, ssb_m_nx, rx_m_nx, quad_nx, lo_nx, dial_nx};
		end
	end

	// Checks
	`RTC_ASSERT(a_band_in_range, band_q <= BAND_W'(BAND_COUNT - 1), "band index beyond band count")
	`RTC_ASSERT_NEXT(a_tune_in_limits, advance && valid_s1 && !off_q && req_s1 == REQ_TUNE && min_freq_q <= max_freq_q && !cfg_valid, dial_q >= min_freq_q && dial_q <= max_freq_q, "tuned dial outside limits")
	`RTC_ASSERT_NEXT(a_save_clears_dirty, advance && valid_s1 && save_nx, !dirty_q && m_axis_tdata[85], "save did not clear dirty")
	`RTC_ASSERT_NEXT(a_off_ignores, advance && valid_s1 && off_q && req_s1 != REQ_WAKE, $stable(dial_q) && $stable(band_q) && off_q, "command acted in soft off")

endmodule

// File: dv/tb_radio_tuning_controller_core.sv
// Self-checking testbench of the radio tuning controller core.
`timescale 1ns / 1ps

module tb_radio_tuning_controller_core;
	import rtc_pkg::*;

	localparam int BANDS           = 10;
	localparam int ROUNDS          = 8;
	localparam int ITEMS_PER_ROUND = 175;
	localparam int DIRECTED_ROWS   = 25;

	// One front-panel readout, packed the way the result item carries it
	typedef struct packed {
		logic        save;
		logic        off;
		logic        lo_en;
		logic [19:0] step;
		logic [3:0]  filter;
		logic [2:0]  mode;
		logic        cw_mute;
		logic        ssb_mute;
		logic        rx_mute;
		logic        quad;
		logic [25:0] lo;
		logic [25:0] dial;
	} panel_readout_t;

	// Directed command with the readout fields that are obvious from the spec
	typedef struct packed {
		req_t              req;
		logic signed [7:0] delta;
		logic              typed;
		logic [25:0]       dial;
		logic [3:0]        filter;
		logic              save;
		logic              off;
	} panel_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_FREQ;
	logic [DIAL_W-1:0]     cfg_data = '0;

	// Predicted panel state and limits
	logic [25:0] min_q, max_q;
	logic [11:0] pitch_q;
	logic [25:0] dial_q;
	mode_t       mode_q;
	logic [3:0]  band_q;
	logic [2:0]  step_q;
	logic [25:0] band_freq_q [16];
	mode_t       band_mode_q [16];
	logic        dirty_q, tx_q, off_q;

	panel_readout_t readouts_due [$];
	panel_row_t     directed_rows [DIRECTED_ROWS];

	int snd_gap_pct   = 0;
	int rcv_stall_pct = 0;
	int error_count   = 0;
	int items_sent    = 0;
	int readouts_seen = 0;
	int saves_seen    = 0;
	int off_seen      = 0;
	int cfg_writes    = 0;

	radio_tuning_controller_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned step_size(input logic [2:0] sel);
		case (sel)
			3'd0:    return 1;
			3'd1:    return 10;
			3'd2:    return 100;
			3'd3:    return 1000;
			3'd4:    return 10000;
			3'd5:    return 100000;
			3'd6:    return 1000000;
			default: return 1;
		endcase
	endfunction

	// Raise to the lower limit, then lower to the upper one, so upper wins when crossed
	function automatic logic [25:0] clamp_hz(input longint hz);
		if (hz < longint'(min_q))
			hz = longint'(min_q);
		if (hz > longint'(max_q))
			hz = longint'(max_q);
		return hz[25:0];
	endfunction

	function automatic void store_current_band();
		band_freq_q[band_q] = clamp_hz(longint'(dial_q));
		band_mode_q[band_q] = mode_q;
	endfunction

	function automatic logic commit_if_dirty();
		if (!dirty_q)
			return 1'b0;
		store_current_band();
		dirty_q = 1'b0;
		return 1'b1;
	endfunction

	// Advance the panel state by one command and work out its readout
	function automatic panel_readout_t apply_command(input req_t r, input logic signed [7:0] d);
		panel_readout_t res;
		longint         target;
		res = '0;
		if (off_q) begin
			if (r == REQ_WAKE)
				off_q = 1'b0;
		end else begin
			case (r)
				REQ_TUNE: begin
					target = longint'(dial_q) + longint'(d) * longint'(step_size(step_q));
					dial_q = clamp_hz(target);
					band_freq_q[band_q] = dial_q;
					dirty_q = 1'b1;
				end
				REQ_MODE: begin
					mode_q = (mode_q == MODE_WSPR) ? MODE_LSB : mode_t'(mode_q + 3'd1);
					store_current_band();
					dirty_q = 1'b1;
				end
				REQ_BAND: begin
					// swap band memory; a band change always ends in a save
					store_current_band();
					band_q = (band_q == BANDS - 1) ? 4'd0 : band_q + 4'd1;
					dial_q = band_freq_q[band_q];
					mode_q = band_mode_q[band_q];
					store_current_band();
					dirty_q = 1'b0;
					res.save = 1'b1;
				end
				REQ_STEP: begin
					step_q = (step_q == 3'd6) ? 3'd0 : step_q + 3'd1;
					store_current_band();
					dirty_q = 1'b1;
				end
				REQ_SAVE: res.save = commit_if_dirty();
				REQ_TX:   tx_q = !tx_q;
				REQ_OFF: begin
					res.save = commit_if_dirty();
					tx_q = 1'b0;
					off_q = 1'b1;
				end
				default: ;
			endcase
		end

		res.dial = dial_q;
		if (mode_q == MODE_CW)
			res.lo = (dial_q > {14'd0, pitch_q}) ? dial_q - {14'd0, pitch_q} : min_q;
		else
			res.lo = dial_q;
		res.quad = (mode_q == MODE_USB) || (mode_q == MODE_FT8) || (mode_q == MODE_WSPR);
		if (off_q || tx_q) begin
			res.rx_mute  = 1'b1;
			res.ssb_mute = 1'b1;
			res.cw_mute  = 1'b1;
		end else begin
			res.rx_mute  = 1'b0;
			res.ssb_mute = (mode_q == MODE_CW);
			res.cw_mute  = (mode_q != MODE_CW);
		end
		res.mode   = mode_q;
		res.filter = off_q ? 4'd0 : band_q;
		res.step   = 20'(step_size(step_q));
		res.lo_en  = !off_q;
		res.off    = off_q;
		return res;
	endfunction

	// Offer one command item, with random idle cycles first, and predict its readout
	task automatic send_cmd(input req_t r, input logic signed [7:0] d,
			output panel_readout_t want);
		while ($urandom_range(99) < snd_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= IN_DATA_W'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, d, r};
		do @(posedge clk); while (!s_axis_tready);
		want = apply_command(r, d);
		readouts_due.push_back(want);
		items_sent++;
	endtask

	// Write one configuration register; the caller drops cfg_valid after the batch
	task automatic write_reg(input cfg_idx_t idx, input logic [25:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MIN_FREQ: min_q = val;
			CFG_MAX_FREQ: max_q = val;
			CFG_CW_PITCH: pitch_q = val[11:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Hold the sender until every readout is back, then let the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (readouts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string label, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: readout %0d %s expected %0d got %0d",
				$time, readouts_seen, label, want, got);
		end
	endtask

	// Receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);

	// Compare each readout with the oldest prediction
	always @(posedge clk) begin
		panel_readout_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (readouts_due.size() == 0) begin
				error_count++;
				$display("%0t: readout with nothing expected, tdata %h", $time, m_axis_tdata);
			end else begin
				want = readouts_due.pop_front();
				check_field("dial_hz",      want.dial,     m_axis_tdata[25:0]);
				check_field("lo_hz",        want.lo,       m_axis_tdata[51:26]);
				check_field("quad_reverse", want.quad,     m_axis_tdata[52]);
				check_field("rx_muted",     want.rx_mute,  m_axis_tdata[53]);
				check_field("ssb_muted",    want.ssb_mute, m_axis_tdata[54]);
				check_field("cw_muted",     want.cw_mute,  m_axis_tdata[55]);
				check_field("mode_code",    want.mode,     m_axis_tdata[58:56]);
				check_field("filter_code",  want.filter,   m_axis_tdata[62:59]);
				check_field("step_hz",      want.step,     m_axis_tdata[82:63]);
				check_field("lo_enabled",   want.lo_en,    m_axis_tdata[83]);
				check_field("powered_off",  want.off,      m_axis_tdata[84]);
				check_field("save_request", want.save,     m_axis_tdata[85]);
				if (want.save)
					saves_seen++;
				if (want.off)
					off_seen++;
				readouts_seen++;
			end
		end
	end

	initial begin
		panel_readout_t    want;
		req_t              r;
		logic signed [7:0] d;
		logic [25:0]       lim_lo, lim_hi, pitch_word;
		int                pick;

		// predictor reset state
		min_q   = 26'd1000000;
		max_q   = 26'd54000000;
		pitch_q = 12'd700;
		dial_q  = 26'd1825000;
		mode_q  = MODE_LSB;
		band_q  = 4'd1;
		step_q  = 3'd2;
		band_freq_q = '{
			26'd1900000,  26'd3575000,  26'd7067000,  26'd10136000,
			26'd14074000, 26'd18100000, 26'd21074000, 26'd24915000,
			26'd28074000, 26'd50313000, 26'd1000000,  26'd1000000,
			26'd1000000,  26'd1000000,  26'd1000000,  26'd1000000
		};
		foreach (band_mode_q[i])
			band_mode_q[i] = MODE_LSB;
		dirty_q = 1'b0;
		tx_q    = 1'b0;
		off_q   = 1'b0;

		// req, delta, typed, dial, filter, save, off
		directed_rows = '{
			'{REQ_TUNE, 8'sh00, 1'b1, 26'd1825000,  4'd1, 1'b0, 1'b0},
			'{REQ_TUNE, 8'sh7F, 1'b1, 26'd1837700,  4'd1, 1'b0, 1'b0},
			'{REQ_STEP, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_STEP, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_STEP, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_STEP, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_TUNE, 8'sh7F, 1'b1, 26'd54000000, 4'd1, 1'b0, 1'b0},
			'{REQ_TUNE, 8'sh80, 1'b1, 26'd1000000,  4'd1, 1'b0, 1'b0},
			'{REQ_STEP, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_SAVE, 8'sh00, 1'b1, 26'd1000000,  4'd1, 1'b1, 1'b0},
			'{REQ_SAVE, 8'sh00, 1'b1, 26'd1000000,  4'd1, 1'b0, 1'b0},
			'{REQ_BAND, 8'sh00, 1'b1, 26'd7067000,  4'd2, 1'b1, 1'b0},
			'{REQ_TX,   8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_WAKE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_OFF,  8'sh00, 1'b1, 26'd7067000,  4'd0, 1'b1, 1'b1},
			'{REQ_TUNE, 8'sh80, 1'b1, 26'd7067000,  4'd0, 1'b0, 1'b1},
			'{REQ_BAND, 8'sh00, 1'b1, 26'd7067000,  4'd0, 1'b0, 1'b1},
			'{REQ_WAKE, 8'sh00, 1'b1, 26'd7067000,  4'd2, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0},
			'{REQ_MODE, 8'sh00, 1'b0, 26'd0,        4'd0, 1'b0, 1'b0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands at the reset limits
		foreach (directed_rows[i]) begin
			send_cmd(directed_rows[i].req, directed_rows[i].delta, want);
			if (directed_rows[i].typed && (want.dial != directed_rows[i].dial ||
					want.filter != directed_rows[i].filter ||
					want.save != directed_rows[i].save || want.off != directed_rows[i].off)) begin
				error_count++;
				$display("%0t: row %0d expected dial %0d filter %0d save %b off %b, got %0d %0d %b %b",
					$time, i, directed_rows[i].dial, directed_rows[i].filter,
					directed_rows[i].save, directed_rows[i].off,
					want.dial, want.filter, want.save, want.off);
			end
		end

		// Random commands under a new set of limits and idling each round
		for (int round = 0; round < ROUNDS; round++) begin
			wait_idle();
			case (round)
				0: begin
					lim_lo = 26'd0;
					lim_hi = 26'h3FFFFFF;
					pitch_word = 26'hFFF;
				end
				1: begin
					lim_lo = 26'($urandom_range(2000000));
					lim_hi = 26'($urandom_range(60000000, 3000000));
					pitch_word = 26'($urandom);
				end
				2: begin
					// crossed limits: the upper one wins
					lim_lo = 26'($urandom_range(60000000, 30000000));
					lim_hi = 26'($urandom_range(29000000, 1000000));
					pitch_word = 26'($urandom);
				end
				3: begin
					// dial often at or below the CW pitch
					lim_lo = 26'd0;
					lim_hi = 26'd6000;
					pitch_word = 26'({$urandom_range(16383), 12'hFFF});
				end
				4: begin
					lim_lo = 26'($urandom_range(67108863));
					lim_hi = lim_lo;
					pitch_word = 26'($urandom);
				end
				5: begin
					lim_lo = 26'd1000000;
					lim_hi = 26'd54000000;
					pitch_word = 26'd700;
				end
				6: begin
					lim_lo = 26'($urandom);
					lim_hi = 26'($urandom);
					pitch_word = 26'($urandom);
				end
				default: begin
					lim_lo = 26'd0;
					lim_hi = 26'h3FFFFFF;
					pitch_word = 26'({$urandom_range(16383), 12'h000});
				end
			endcase
			write_reg(CFG_MIN_FREQ, lim_lo);
			write_reg(CFG_MAX_FREQ, lim_hi);
			write_reg(CFG_CW_PITCH, pitch_word);
			cfg_valid <= 1'b0;

			case (round % 4)
				0: begin
					snd_gap_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_gap_pct = 49;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_gap_pct = 0;
					rcv_stall_pct = 49;
				end
				default: begin
					snd_gap_pct = 6;
					rcv_stall_pct = 6;
				end
			endcase

			repeat (ITEMS_PER_ROUND) begin
				// mostly wake from soft off so the rest of the commands do work
				if (off_q && $urandom_range(9) < 7) begin
					r = REQ_WAKE;
				end else begin
					pick = $urandom_range(99);
					if (pick < 40)
						r = REQ_TUNE;
					else if (pick < 52)
						r = REQ_MODE;
					else if (pick < 64)
						r = REQ_BAND;
					else if (pick < 74)
						r = REQ_STEP;
					else if (pick < 82)
						r = REQ_SAVE;
					else if (pick < 90)
						r = REQ_TX;
					else if (pick < 95)
						r = REQ_OFF;
					else
						r = REQ_WAKE;
				end
				case ($urandom_range(9))
					0:       d = 8'sh7F;
					1:       d = 8'sh80;
					default: d = 8'($urandom);
				endcase
				send_cmd(r, d, want);
				if ($urandom_range(199) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (readouts_due.size() != 0) begin
			error_count++;
			$display("%0t: %0d readouts never arrived", $time, readouts_due.size());
		end

		$display("Ran %0d commands, %0d readouts compared, %0d limit writes over %0d settings.",
			items_sent, readouts_seen, cfg_writes, ROUNDS + 1);
		$display("Readouts included %0d save requests and %0d in soft off.", saves_seen, off_seen);
		if (error_count == 0)
			$display("tb_radio_tuning_controller_core: done, clean");
		else
			$display("tb_radio_tuning_controller_core: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d readouts outstanding", $time, readouts_due.size());
		$display("tb_radio_tuning_controller_core: done, errors");
		$finish;
	end

endmodule
